/* rtl/csv_field_tokenizer_core_assert.svh */
// ----------------------------------------------------------------------------
// CSV field tokenizer assertion macros
// Shared property forms for the tokenizer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/cft_pkg.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Beat types, tokenizer state, register indexes and result codes.
// ----------------------------------------------------------------------------
package cft_pkg;

   localparam int unsigned RSP_SLOTS = 3;

   localparam logic [20:0] FIELD_LIMIT = 21'd1048576;
   localparam logic [32:0] CELL_SAT    = 33'h1_0000_0000;

   localparam logic [15:0] QUOTE_CU = 16'h0022;
   localparam logic [15:0] LF_CU    = 16'h000A;
   localparam logic [15:0] CR_CU    = 16'h000D;

   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_FIELD_END = 2'd1;
   localparam logic [1:0] KIND_ROW_END   = 2'd2;
   localparam logic [1:0] KIND_FINISHED  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [1:0] STATUS_NO_DATA   = 2'd2;

   localparam logic [1:0] CSR_DELIMITER  = 2'd0;
   localparam logic [1:0] CSR_CELL_LIMIT = 2'd1;
   localparam logic [1:0] CSR_ROW_LIMIT  = 2'd2;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        text_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] char_out;
      logic        quote_flag;
      logic [1:0]  status;
      logic        final_res;
   } rsp_type;

   typedef struct packed {
      logic [15:0] delimiter;
      logic [31:0] cell_limit;
      logic [15:0] row_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      delimiter:  16'd44,
      cell_limit: 32'hFFFF_FFFF,
      row_limit:  16'hFFFF
   };

   typedef struct packed {
      logic        inside_quotes;
      logic        quote_pending;
      logic        field_quoted;
      logic [20:0] field_length;
      logic [32:0] row_cell_count;
      logic [32:0] total_cell_count;
      logic [16:0] row_count;
      logic        failed;
   } state_type;

   localparam state_type STATE_RESET = '0;

   function automatic rsp_type mk_char(input logic [15:0] ch);
      rsp_type r;
      r = '0;
      r.kind = KIND_CHAR;
      r.char_out = ch;
      return r;
   endfunction

   function automatic rsp_type mk_end(input logic [1:0] kind, input logic quoted);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.quote_flag = quoted;
      return r;
   endfunction

   function automatic rsp_type mk_fin(input logic [1:0] status, input logic fin);
      rsp_type r;
      r = '0;
      r.kind = KIND_FINISHED;
      r.status = status;
      r.final_res = fin;
      return r;
   endfunction

endpackage

/* rtl/cft_step.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer step
// Next tokenizer state and up to three results for one code unit.
// ----------------------------------------------------------------------------
module cft_step import cft_pkg::*; (
   input  state_type   cur_state,
   input  cfg_type     cfg,
   input  req_type     item,
   output state_type   nxt_state,
   output logic [1:0]  rsp_count,
   output rsp_type     rsp_list [RSP_SLOTS]
);

   state_type   st;
   logic [1:0]  n;
   logic        consumed;
   logic        row_req;
   logic        fail;
   logic [33:0] total_sum;
   logic [32:0] total_sat;

   always_comb begin
      st = cur_state;
      n = '0;
      for (int i = 0; i < RSP_SLOTS; i++) begin
         rsp_list[i] = '0;
      end
      consumed = 1'b0;
      row_req = 1'b0;
      fail = 1'b0;
      total_sum = '0;
      total_sat = '0;

      if (cur_state.failed) begin
         if (item.text_end) begin
            rsp_list[n] = mk_fin(STATUS_TOO_LARGE, 1'b1);
            n = n + 2'd1;
            st = STATE_RESET;
         end
      end else begin
         if (st.quote_pending) begin
            st.quote_pending = 1'b0;
            if (item.code_unit == QUOTE_CU) begin
               rsp_list[n] = mk_char(QUOTE_CU);
               n = n + 2'd1;
               if (st.field_length <= FIELD_LIMIT) begin
                  st.field_length = st.field_length + 21'd1;
               end
               consumed = 1'b1;
            end else begin
               st.inside_quotes = 1'b0;
            end
         end

         if (!consumed) begin
            if (st.inside_quotes) begin
               if (item.code_unit == QUOTE_CU) begin
                  st.quote_pending = 1'b1;
               end else begin
                  rsp_list[n] = mk_char(item.code_unit);
                  n = n + 2'd1;
                  if (st.field_length <= FIELD_LIMIT) begin
                     st.field_length = st.field_length + 21'd1;
                  end
               end
            end else if (item.code_unit == QUOTE_CU) begin
               st.inside_quotes = 1'b1;
               st.field_quoted = 1'b1;
               if (st.field_length > FIELD_LIMIT) begin
                  fail = 1'b1;
               end
            end else if (item.code_unit == cfg.delimiter) begin
               rsp_list[n] = mk_end(KIND_FIELD_END, st.field_quoted);
               n = n + 2'd1;
               st.field_quoted = 1'b0;
               st.field_length = '0;
               if (st.row_cell_count < CELL_SAT) begin
                  st.row_cell_count = st.row_cell_count + 33'd1;
               end
            end else if (item.code_unit == LF_CU) begin
               row_req = 1'b1;
            end else if (item.code_unit == CR_CU) begin
               if (st.field_length > FIELD_LIMIT) begin
                  fail = 1'b1;
               end
            end else begin
               if (st.field_length <= FIELD_LIMIT) begin
                  st.field_length = st.field_length + 21'd1;
               end
               if (st.field_length > FIELD_LIMIT) begin
                  fail = 1'b1;
               end else begin
                  rsp_list[n] = mk_char(item.code_unit);
                  n = n + 2'd1;
               end
            end
         end

         if (!fail && (row_req || (item.text_end && (st.field_length != '0 ||
               st.row_cell_count != '0 || st.field_quoted)))) begin
            total_sum = {1'b0, st.total_cell_count} + {1'b0, st.row_cell_count} + 34'd1;
            total_sat = (total_sum > {1'b0, CELL_SAT}) ? CELL_SAT : total_sum[32:0];
            st.total_cell_count = total_sat;
            if (total_sat > {1'b0, cfg.cell_limit} ||
                  st.row_count >= ({1'b0, cfg.row_limit} + 17'd1)) begin
               fail = 1'b1;
            end else begin
               st.row_count = st.row_count + 17'd1;
               rsp_list[n] = mk_end(KIND_ROW_END, st.field_quoted);
               n = n + 2'd1;
               st.field_quoted = 1'b0;
               st.field_length = '0;
               st.row_cell_count = '0;
            end
         end

         if (fail) begin
            rsp_list[n] = mk_fin(STATUS_TOO_LARGE, item.text_end);
            n = n + 2'd1;
            if (item.text_end) begin
               st = STATE_RESET;
            end else begin
               st.failed = 1'b1;
            end
         end else if (item.text_end) begin
            rsp_list[n] = mk_fin((st.row_count == '0) ? STATUS_NO_DATA : STATUS_OK, 1'b1);
            n = n + 2'd1;
            st = STATE_RESET;
         end
      end

      nxt_state = st;
      rsp_count = n;
   end

endmodule

/* rtl/csv_field_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// Streaming quote-aware CSV tokenizer over 16-bit code units.
// ----------------------------------------------------------------------------
// The req channel carries one code unit per beat with a flag on the last unit
// of the text. The rsp channel carries field characters, field ends, row ends
// and a finished beat with a status for each text. Both channels use valid
// and stall; a beat moves on a clock edge with valid high and stall low.
// The user must write the registers (delimiter, cell and row limits) on the
// csr port only while the block is idle; the block has no check for it.
// A code unit is captured in an input register and decoded once the result
// buffer is empty or handing out its last beat; its zero to three results are
// registered into the three-entry result buffer, whose head is offered on rsp.
// One code unit is taken per cycle when each unit yields at most one result
// and rsp does not stall; a unit with more results holds up the next unit
// until its results drain, since the buffer drains one beat per cycle.
// A stall on rsp holds the buffer and backs up into req_stall.
// Reset empties both stages, clears the tokenizer state and loads the
// register defaults.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_core_assert.svh"

module csv_field_tokenizer_core import cft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff, in_data_in;
   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   rsp_type    buf_ff [RSP_SLOTS];
   rsp_type    buf_in [RSP_SLOTS];
   logic [1:0] cnt_ff, cnt_in;

   state_type  step_state;
   logic [1:0] step_cnt;
   rsp_type    step_list [RSP_SLOTS];

   logic pop;
   logic run_step;
   logic load;

   cft_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .item      (in_data_ff),
      .nxt_state (step_state),
      .rsp_count (step_cnt),
      .rsp_list  (step_list)
   );

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign run_step  = in_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop));
   assign req_stall = in_valid_ff && !run_step;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in = in_data_ff;
      if (load) begin
         in_valid_in = 1'b1;
         in_data_in = req_data;
      end else if (run_step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (run_step) begin
         state_in = step_state;
         buf_in = step_list;
         cnt_in = step_cnt;
      end else if (pop) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DELIMITER:  cfg_in.delimiter = csr_wdata[15:0];
            CSR_CELL_LIMIT: cfg_in.cell_limit = csr_wdata;
            CSR_ROW_LIMIT:  cfg_in.row_limit = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= STATE_RESET;
         cfg_ff <= CFG_RESET;
         cnt_ff <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      buf_ff <= buf_in;
   end

   `CFT_ASSERT_NEXT(a_text_end_clears, run_step && in_data_ff.text_end,
      state_ff == STATE_RESET, "tokenizer state not cleared after the last code unit")
   `CFT_ASSERT_NOW(a_finish_is_last, run_step && (step_cnt == 2'd2 || step_cnt == 2'd3),
      step_list[0].kind != KIND_FINISHED, "finished beat is not the last of its group")
   `CFT_ASSERT_NOW(a_full_buffer_stalls, in_valid_ff && (cnt_ff == 2'd2 || cnt_ff == 2'd3),
      req_stall, "code unit taken while the result buffer still holds several beats")

endmodule
